[rtl/lpe_pkg.sv]
package lpe_pkg;

    // result codes on the output channel
    typedef enum logic [1:0] {
        KIND_BYTE  = 2'd0,
        KIND_EMPTY = 2'd1,
        KIND_BAD   = 2'd2
    } kind_t;

    // per-pixel control carried from the header stage to the payload stage
    typedef struct packed {
        logic first;
        logic hdr_done;
        logic hdr_short;
        logic hdr_empty;
    } hdr_ctl_t;

    localparam int unsigned LANES   = 4;
    localparam int unsigned CHAN_W  = 8;
    localparam int unsigned COUNT_W = 4;
    localparam int unsigned BYTE_W  = 8;

endpackage

[rtl/lpe_lane.sv]
module lpe_lane import lpe_pkg::*; #(
    parameter int unsigned MAX_CHANNEL_BITS = 8
) (
    input  logic [CHAN_W-1:0]                       value,
    input  logic [COUNT_W-1:0]                      count,
    output logic [MAX_CHANNEL_BITS-1:0]             bits,
    output logic [$clog2(MAX_CHANNEL_BITS+1)-1:0]   num
);

    localparam int unsigned LN_W = $clog2(MAX_CHANNEL_BITS + 1);

    logic [COUNT_W-1:0] clamped;

    // clamp the count, then left-align the hidden bits msb first
    always_comb begin
        clamped = (count > COUNT_W'(MAX_CHANNEL_BITS)) ? COUNT_W'(MAX_CHANNEL_BITS) : count;
        num     = LN_W'(clamped);
        bits    = value[MAX_CHANNEL_BITS-1:0] << (COUNT_W'(MAX_CHANNEL_BITS) - clamped);
    end

endmodule

[rtl/lpe_merge.sv]
module lpe_merge import lpe_pkg::*; #(
    parameter int unsigned MAX_CHANNEL_BITS = 8
) (
    input  logic                                                aclk,
    input  logic                                                aresetn,
    input  logic                                                in_valid,
    output logic                                                in_ready,
    input  logic                                                in_first,
    input  logic [LANES-1:0][MAX_CHANNEL_BITS-1:0]              lane_bits,
    input  logic [LANES-1:0][$clog2(MAX_CHANNEL_BITS+1)-1:0]    lane_num,
    output logic                                                out_valid,
    input  logic                                                out_ready,
    output logic                                                out_first,
    output logic [LANES*MAX_CHANNEL_BITS-1:0]                   out_bits,
    output logic [$clog2(LANES*MAX_CHANNEL_BITS+1)-1:0]         out_num
);

    localparam int unsigned PIX_BITS = LANES * MAX_CHANNEL_BITS;
    localparam int unsigned NW       = $clog2(PIX_BITS + 1);
    localparam int unsigned PAD      = PIX_BITS - MAX_CHANNEL_BITS;

    logic [PIX_BITS-1:0] bits_next;
    logic [NW-1:0]       num_next;
    logic                valid_reg;
    logic                first_reg;
    logic [PIX_BITS-1:0] bits_reg;
    logic [NW-1:0]       num_reg;

    // pack lane fields back to back, red lane first
    always_comb begin
        bits_next = '0;
        num_next  = '0;
        for (int i = 0; i < LANES; i++) begin
            bits_next = bits_next | ({lane_bits[i], {PAD{1'b0}}} >> num_next);
            num_next  = num_next + NW'(lane_num[i]);
        end
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_first = first_reg;
    assign out_bits  = bits_reg;
    assign out_num   = num_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            first_reg <= in_first;
            bits_reg  <= bits_next;
            num_reg   <= num_next;
        end
    end

endmodule

[rtl/lpe_header.sv]
module lpe_header import lpe_pkg::*; #(
    parameter int unsigned HEADER_BITS = 64,
    parameter int unsigned PIX_BITS    = 32
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic                            in_first,
    input  logic [PIX_BITS-1:0]             in_bits,
    input  logic [$clog2(PIX_BITS+1)-1:0]   in_num,
    output logic                            out_valid,
    input  logic                            out_ready,
    output hdr_ctl_t                        out_ctl,
    output logic [PIX_BITS-1:0]             out_bits,
    output logic [$clog2(PIX_BITS+1)-1:0]   out_num,
    output logic [HEADER_BITS-4:0]          out_body
);

    localparam int unsigned NW    = $clog2(PIX_BITS + 1);
    localparam int unsigned SW    = $clog2(HEADER_BITS + 1);
    localparam int unsigned TW    = (SW > NW) ? SW : NW;
    localparam int unsigned RB    = HEADER_BITS - 3;
    localparam int unsigned CAT_W = HEADER_BITS + PIX_BITS;

    // header collection state
    logic [HEADER_BITS-1:0] shift_reg;
    logic [SW-1:0]          seen_reg;
    logic                   active_reg;

    logic                   act;
    logic [SW-1:0]          seen_cur;
    logic [HEADER_BITS-1:0] shift_cur;
    logic [TW-1:0]          need;
    logic [TW-1:0]          take;
    logic [CAT_W-1:0]       cat;
    logic [HEADER_BITS-1:0] shift_next;
    logic [SW-1:0]          seen_next;
    logic                   done;
    logic                   active_next;

    // stage a: bits left after the header, completed length
    logic                   a_valid_reg;
    logic                   a_first_reg;
    logic                   a_done_reg;
    logic [PIX_BITS-1:0]    a_bits_reg;
    logic [NW-1:0]          a_num_reg;
    logic [HEADER_BITS-1:0] a_len_reg;
    logic                   a_ready;

    // stage b: decoded length
    logic                   b_valid_reg;
    hdr_ctl_t               b_ctl_reg;
    logic [PIX_BITS-1:0]    b_bits_reg;
    logic [NW-1:0]          b_num_reg;
    logic [RB-1:0]          b_body_reg;
    logic                   b_ready;

    logic [HEADER_BITS-1:0] diff;
    hdr_ctl_t               ctl_next;

    always_comb begin
        act       = in_first || active_reg;
        seen_cur  = in_first ? '0 : seen_reg;
        shift_cur = in_first ? '0 : shift_reg;
        need      = TW'(HEADER_BITS) - TW'(seen_cur);
        if (!act) begin
            take = '0;
        end else if (TW'(in_num) < need) begin
            take = TW'(in_num);
        end else begin
            take = need;
        end
        cat         = {shift_cur, in_bits} << take;
        shift_next  = cat[CAT_W-1 -: HEADER_BITS];
        seen_next   = seen_cur + SW'(take);
        done        = act && (TW'(seen_next) == TW'(HEADER_BITS));
        active_next = act && !done;
    end

    always_comb begin
        diff               = a_len_reg - HEADER_BITS'(HEADER_BITS);
        ctl_next.first     = a_first_reg;
        ctl_next.hdr_done  = a_done_reg;
        ctl_next.hdr_short = a_len_reg < HEADER_BITS'(HEADER_BITS);
        ctl_next.hdr_empty = (diff[HEADER_BITS-1:3] == '0);
    end

    assign b_ready   = !b_valid_reg || out_ready;
    assign a_ready   = !a_valid_reg || b_ready;
    assign in_ready  = a_ready;
    assign out_valid = b_valid_reg;
    assign out_ctl   = b_ctl_reg;
    assign out_bits  = b_bits_reg;
    assign out_num   = b_num_reg;
    assign out_body  = b_body_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            shift_reg   <= '0;
            seen_reg    <= '0;
            active_reg  <= 1'b1;
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end else begin
            if (in_valid && a_ready) begin
                shift_reg  <= shift_next;
                seen_reg   <= seen_next;
                active_reg <= active_next;
            end
            if (a_ready) begin
                a_valid_reg <= in_valid;
            end
            if (b_ready) begin
                b_valid_reg <= a_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && a_ready) begin
            a_first_reg <= in_first;
            a_done_reg  <= done;
            a_bits_reg  <= in_bits << take;
            a_num_reg   <= in_num - NW'(take);
            a_len_reg   <= shift_next;
        end
        if (a_valid_reg && b_ready) begin
            b_ctl_reg  <= ctl_next;
            b_bits_reg <= a_bits_reg;
            b_num_reg  <= a_num_reg;
            b_body_reg <= diff[HEADER_BITS-1:3];
        end
    end

`ifndef NO_ASSERTIONS
    a_seen_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        active_reg |-> seen_reg < SW'(HEADER_BITS))
        else $error("header bit count past header length while collecting");
`endif

endmodule

[rtl/lpe_payload.sv]
module lpe_payload import lpe_pkg::*; #(
    parameter int unsigned HEADER_BITS = 64,
    parameter int unsigned PIX_BITS    = 32
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  hdr_ctl_t                        in_ctl,
    input  logic [PIX_BITS-1:0]             in_bits,
    input  logic [$clog2(PIX_BITS+1)-1:0]   in_num,
    input  logic [HEADER_BITS-4:0]          in_body,
    output logic                            out_valid,
    input  logic                            out_ready,
    output kind_t                           out_kind,
    output logic [BYTE_W-1:0]               out_byte,
    output logic                            out_last
);

    localparam int unsigned RB      = HEADER_BITS - 3;
    localparam int unsigned MAX_RES = (PIX_BITS + 7) / 8;
    localparam int unsigned RC_W    = $clog2(MAX_RES + 1);
    localparam int unsigned AL_W    = PIX_BITS + 7;
    localparam int unsigned TOT_W   = $clog2(PIX_BITS + 8);

    typedef enum logic [2:0] {
        PH_WAIT = 3'b001,
        PH_BODY = 3'b010,
        PH_DONE = 3'b100
    } phase_t;

    phase_t            phase_reg, phase_cur, phase_next;
    logic [RB-1:0]     rem_reg, rem_cur, rem_next;
    logic [6:0]        part_reg, part_cur, part_next;
    logic [2:0]        pcnt_reg, pcnt_cur, pcnt_next;

    logic              body_on;
    logic [RB-1:0]     body_rem;
    logic [6:0]        body_part;
    logic [2:0]        body_pcnt;
    logic [AL_W-1:0]   aligned;
    logic [AL_W-1:0]   tail;
    logic [TOT_W-1:0]  total;
    logic [RC_W-1:0]   avail;
    logic [RC_W-1:0]   nb;
    logic [RC_W-1:0]   nres;

    logic [BYTE_W-1:0] byte_next [MAX_RES];
    kind_t             kind_next [MAX_RES];
    logic              last_next [MAX_RES];
    logic [BYTE_W-1:0] byte_reg  [MAX_RES];
    kind_t             kind_reg  [MAX_RES];
    logic              last_reg  [MAX_RES];
    logic [RC_W-1:0]   left_reg;

    always_comb begin
        phase_cur  = in_ctl.first ? PH_WAIT : phase_reg;
        rem_cur    = in_ctl.first ? '0 : rem_reg;
        part_cur   = in_ctl.first ? '0 : part_reg;
        pcnt_cur   = in_ctl.first ? '0 : pcnt_reg;
        phase_next = phase_cur;
        rem_next   = rem_cur;
        part_next  = part_cur;
        pcnt_next  = pcnt_cur;
        body_on    = 1'b0;
        body_rem   = rem_cur;
        body_part  = part_cur;
        body_pcnt  = pcnt_cur;
        aligned    = '0;
        tail       = '0;
        total      = '0;
        avail      = '0;
        nb         = '0;
        nres       = '0;
        for (int j = 0; j < MAX_RES; j++) begin
            byte_next[j] = '0;
            kind_next[j] = KIND_BYTE;
            last_next[j] = 1'b0;
        end

        if (in_ctl.hdr_done) begin
            if (in_ctl.hdr_short) begin
                kind_next[0] = KIND_BAD;
                last_next[0] = 1'b1;
                nres         = RC_W'(1);
                phase_next   = PH_DONE;
            end else if (in_ctl.hdr_empty) begin
                kind_next[0] = KIND_EMPTY;
                last_next[0] = 1'b1;
                nres         = RC_W'(1);
                phase_next   = PH_DONE;
            end else begin
                body_on   = 1'b1;
                body_rem  = in_body;
                body_part = '0;
                body_pcnt = '0;
            end
        end else if (phase_cur == PH_BODY) begin
            body_on = 1'b1;
        end

        // leftover bits of the previous pixel sit ahead of the new ones
        if (body_on) begin
            aligned = {body_part, in_bits} << (3'd7 - body_pcnt);
            total   = TOT_W'(body_pcnt) + TOT_W'(in_num);
            avail   = RC_W'(total >> 3);
            nb      = (RB'(avail) < body_rem) ? avail : RC_W'(body_rem);
            for (int j = 0; j < MAX_RES; j++) begin
                byte_next[j] = aligned[AL_W-1-8*j -: 8];
                last_next[j] = (RC_W'(j + 1) == nb) && (body_rem == RB'(nb));
            end
            nres      = nb;
            rem_next  = body_rem - RB'(nb);
            tail      = aligned << {avail, 3'b000};
            pcnt_next = total[2:0];
            part_next = tail[AL_W-1 -: 7] >> (3'd7 - total[2:0]);
            if (body_rem == RB'(nb)) begin
                phase_next = PH_DONE;
            end else begin
                phase_next = PH_BODY;
            end
        end
    end

    assign out_valid = (left_reg != '0);
    assign out_kind  = kind_reg[0];
    assign out_byte  = byte_reg[0];
    assign out_last  = last_reg[0];
    assign in_ready  = (left_reg == '0) || ((left_reg == RC_W'(1)) && out_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_WAIT;
            rem_reg   <= '0;
            part_reg  <= '0;
            pcnt_reg  <= '0;
            left_reg  <= '0;
        end else if (in_valid && in_ready) begin
            phase_reg <= phase_next;
            rem_reg   <= rem_next;
            part_reg  <= part_next;
            pcnt_reg  <= pcnt_next;
            left_reg  <= nres;
        end else if (out_valid && out_ready) begin
            left_reg  <= left_reg - RC_W'(1);
        end
    end

    // result buffer, drained from entry zero
    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            for (int j = 0; j < MAX_RES; j++) begin
                byte_reg[j] <= byte_next[j];
                kind_reg[j] <= kind_next[j];
                last_reg[j] <= last_next[j];
            end
        end else if (out_valid && out_ready) begin
            for (int j = 0; j < MAX_RES - 1; j++) begin
                byte_reg[j] <= byte_reg[j+1];
                kind_reg[j] <= kind_reg[j+1];
                last_reg[j] <= last_reg[j+1];
            end
        end
    end

`ifndef NO_ASSERTIONS
    a_last_final: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid && out_last |-> left_reg == RC_W'(1))
        else $error("last result is not the final buffered result");

    a_body_rem: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_BODY |-> rem_reg != '0)
        else $error("payload phase with no bytes remaining");

    a_left_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        left_reg <= RC_W'(MAX_RES))
        else $error("result buffer count past its depth");
`endif

endmodule

[rtl/lsb_payload_extractor.sv]
// pipeline: a pixel is registered in the merge stage, header stages a and b and the result buffer
// throughput: one pixel per cycle while m_ready is held and each pixel yields at most one
//   result; a pixel yielding more results holds the next pixel off until its last result
//   leaves the buffer, at most 4 results per pixel (one byte per cycle out)
// reset: aresetn is synchronous, active low; it empties every stage and the
//   result buffer and leaves the block collecting a new header
module lsb_payload_extractor import lpe_pkg::*; #(
    parameter int unsigned HEADER_BITS      = 64,
    parameter int unsigned MAX_CHANNEL_BITS = 8
) (
    input  logic               aclk,
    input  logic               aresetn,
    // pixel input channel
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_first_pixel,
    input  logic [CHAN_W-1:0]  s_red,
    input  logic [CHAN_W-1:0]  s_green,
    input  logic [CHAN_W-1:0]  s_blue,
    input  logic [CHAN_W-1:0]  s_alpha,
    input  logic [COUNT_W-1:0] s_red_count,
    input  logic [COUNT_W-1:0] s_green_count,
    input  logic [COUNT_W-1:0] s_blue_count,
    input  logic [COUNT_W-1:0] s_alpha_count,
    // result channel
    output logic               m_valid,
    input  logic               m_ready,
    output logic [1:0]         m_kind,
    output logic [BYTE_W-1:0]  m_payload_byte,
    output logic               m_last
);

    localparam int unsigned PIX_BITS = LANES * MAX_CHANNEL_BITS;
    localparam int unsigned LN_W     = $clog2(MAX_CHANNEL_BITS + 1);
    localparam int unsigned NW       = $clog2(PIX_BITS + 1);
    localparam int unsigned RB       = HEADER_BITS - 3;

    // per-channel values and counts, in extraction order r, g, b, a
    logic [LANES-1:0][CHAN_W-1:0]           lane_value;
    logic [LANES-1:0][COUNT_W-1:0]          lane_count;
    logic [LANES-1:0][MAX_CHANNEL_BITS-1:0] lane_bits;
    logic [LANES-1:0][LN_W-1:0]             lane_num;

    // merge stage -> header stage
    logic                mrg_valid;
    logic                mrg_ready;
    logic                mrg_first;
    logic [PIX_BITS-1:0] mrg_bits;
    logic [NW-1:0]       mrg_num;

    // header stage -> payload stage
    logic                hdr_valid;
    logic                hdr_ready;
    hdr_ctl_t            hdr_ctl;
    logic [PIX_BITS-1:0] hdr_bits;
    logic [NW-1:0]       hdr_num;
    logic [RB-1:0]       hdr_body;

    kind_t               pay_kind;

    assign lane_value[0] = s_red;
    assign lane_value[1] = s_green;
    assign lane_value[2] = s_blue;
    assign lane_value[3] = s_alpha;
    assign lane_count[0] = s_red_count;
    assign lane_count[1] = s_green_count;
    assign lane_count[2] = s_blue_count;
    assign lane_count[3] = s_alpha_count;

    // one lane per channel: clamp the count and left-align the hidden bits
    for (genvar g = 0; g < LANES; g++) begin : g_lane
        lpe_lane #(
            .MAX_CHANNEL_BITS (MAX_CHANNEL_BITS)
        ) u_lane (
            .value (lane_value[g]),
            .count (lane_count[g]),
            .bits  (lane_bits[g]),
            .num   (lane_num[g])
        );
    end

    // lanes are packed into one msb-first bit run per pixel and registered
    lpe_merge #(
        .MAX_CHANNEL_BITS (MAX_CHANNEL_BITS)
    ) u_merge (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_first  (s_first_pixel),
        .lane_bits (lane_bits),
        .lane_num  (lane_num),
        .out_valid (mrg_valid),
        .out_ready (mrg_ready),
        .out_first (mrg_first),
        .out_bits  (mrg_bits),
        .out_num   (mrg_num)
    );

    // header collection strips the length bits, then the length is decoded
    // into a whole-byte count and the bad/empty checks
    lpe_header #(
        .HEADER_BITS (HEADER_BITS),
        .PIX_BITS    (PIX_BITS)
    ) u_header (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (mrg_valid),
        .in_ready  (mrg_ready),
        .in_first  (mrg_first),
        .in_bits   (mrg_bits),
        .in_num    (mrg_num),
        .out_valid (hdr_valid),
        .out_ready (hdr_ready),
        .out_ctl   (hdr_ctl),
        .out_bits  (hdr_bits),
        .out_num   (hdr_num),
        .out_body  (hdr_body)
    );

    // byte assembly, end-of-payload tracking and a small result buffer that
    // lets the next pixel in as the last buffered result leaves
    lpe_payload #(
        .HEADER_BITS (HEADER_BITS),
        .PIX_BITS    (PIX_BITS)
    ) u_payload (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (hdr_valid),
        .in_ready  (hdr_ready),
        .in_ctl    (hdr_ctl),
        .in_bits   (hdr_bits),
        .in_num    (hdr_num),
        .in_body   (hdr_body),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_kind  (pay_kind),
        .out_byte  (m_payload_byte),
        .out_last  (m_last)
    );

    assign m_kind = pay_kind;

endmodule

[tb/tb_lsb_payload_extractor.sv]
module tb_lsb_payload_extractor import lpe_pkg::*;;

    timeunit 1ns;
    timeprecision 1ps;

    // header length of the block as built (default parameters)
    localparam int HDR_BITS        = 64;
    localparam int CHAN_BITS_MAX   = 8;
    localparam int GAP_MAX         = 14;
    localparam int RANDOM_PIXELS   = 380;
    localparam int WATCHDOG_CYCLES = 2000;
    localparam int REPORT_LIMIT    = 10;
    localparam int DRAIN_CYCLES    = 20;

    // how the per-channel hidden bit counts of a frame are chosen
    typedef enum int {
        COUNTS_RANDOM,
        COUNTS_FULL,
        COUNTS_OVER
    } count_mode_t;

    // one pixel transfer; lane 0 is red, then green, blue, alpha
    typedef struct packed {
        logic                           first;
        logic [LANES-1:0][CHAN_W-1:0]   chan;
        logic [LANES-1:0][COUNT_W-1:0]  cnt;
    } pixel_t;

    // one result transfer
    typedef struct packed {
        kind_t              kind;
        logic [BYTE_W-1:0]  data;
        logic               last;
    } result_t;

    // tracks the hidden-bit stream of the current frame and holds the results it implies
    class hidden_payload_board;
        typedef enum logic [1:0] {
            COLLECT_HEADER  = 2'd0,
            COLLECT_PAYLOAD = 2'd1,
            FRAME_DONE      = 2'd2
        } frame_phase_t;

        frame_phase_t  phase;
        logic [63:0]   header_shift;
        logic [6:0]    header_bits_seen;
        logic [63:0]   bits_remaining;
        logic [7:0]    byte_assembly;
        logic [2:0]    byte_bit_count;

        result_t       pending_results[$];
        int            mismatches;
        int            bytes_seen;
        int            empty_seen;
        int            bad_seen;

        function new();
            clear_frame();
            mismatches = 0;
            bytes_seen = 0;
            empty_seen = 0;
            bad_seen   = 0;
        endfunction

        function void clear_frame();
            phase            = COLLECT_HEADER;
            header_shift     = '0;
            header_bits_seen = '0;
            bits_remaining   = '0;
            byte_assembly    = '0;
            byte_bit_count   = '0;
        endfunction

        function void push_result(kind_t kind, logic [7:0] data, logic last);
            result_t r;
            r.kind = kind;
            r.data = data;
            r.last = last;
            pending_results.push_back(r);
        endfunction

        function void take_hidden_bit(logic b);
            logic [63:0] whole_bytes;
            case (phase)
                COLLECT_HEADER: begin
                    header_shift     = {header_shift[62:0], b};
                    header_bits_seen = header_bits_seen + 7'd1;
                    if (header_bits_seen >= HDR_BITS) begin
                        if (header_shift < HDR_BITS) begin
                            push_result(KIND_BAD, 8'd0, 1'b1);
                            phase = FRAME_DONE;
                        end else begin
                            whole_bytes = (header_shift - HDR_BITS) >> 3;
                            if (whole_bytes == 0) begin
                                push_result(KIND_EMPTY, 8'd0, 1'b1);
                                phase = FRAME_DONE;
                            end else begin
                                bits_remaining = whole_bytes << 3;
                                byte_assembly  = '0;
                                byte_bit_count = '0;
                                phase          = COLLECT_PAYLOAD;
                            end
                        end
                    end
                end
                COLLECT_PAYLOAD: begin
                    byte_assembly  = {byte_assembly[6:0], b};
                    byte_bit_count = byte_bit_count + 3'd1;
                    bits_remaining = bits_remaining - 64'd1;
                    if (byte_bit_count == 0) begin
                        push_result(KIND_BYTE, byte_assembly, bits_remaining == 0);
                        byte_assembly = '0;
                    end
                    if (bits_remaining == 0)
                        phase = FRAME_DONE;
                end
                default: ;
            endcase
        endfunction

        // called for every accepted pixel
        function void note_pixel(pixel_t px);
            int c;
            if (px.first)
                clear_frame();
            for (int ch = 0; ch < LANES; ch++) begin
                c = (px.cnt[ch] > CHAN_BITS_MAX) ? CHAN_BITS_MAX : int'(px.cnt[ch]);
                for (int j = c - 1; j >= 0; j--)
                    take_hidden_bit(px.chan[ch][j]);
            end
        endfunction

        // called for every accepted result
        function void check_result(logic [1:0] kind, logic [7:0] data, logic last);
            result_t want;
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("unexpected result at %0t: kind %0d byte %02h last %0b",
                             $realtime, kind, data, last);
                return;
            end
            want = pending_results.pop_front();
            if (kind !== want.kind || data !== want.data || last !== want.last) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT) begin
                    $write("result mismatch at %0t: expected kind %0d byte %02h last %0b,",
                           $realtime, want.kind, want.data, want.last);
                    $display(" got kind %0d byte %02h last %0b", kind, data, last);
                end
            end else begin
                case (want.kind)
                    KIND_BYTE:  bytes_seen++;
                    KIND_EMPTY: empty_seen++;
                    default:    bad_seen++;
                endcase
            end
        endfunction

        function int pending();
            return pending_results.size();
        endfunction
    endclass

    logic               aclk;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    logic               s_first_pixel;
    logic [CHAN_W-1:0]  s_red;
    logic [CHAN_W-1:0]  s_green;
    logic [CHAN_W-1:0]  s_blue;
    logic [CHAN_W-1:0]  s_alpha;
    logic [COUNT_W-1:0] s_red_count;
    logic [COUNT_W-1:0] s_green_count;
    logic [COUNT_W-1:0] s_blue_count;
    logic [COUNT_W-1:0] s_alpha_count;
    logic               m_valid;
    logic               m_ready;
    logic [1:0]         m_kind;
    logic [BYTE_W-1:0]  m_payload_byte;
    logic               m_last;

    hidden_payload_board board = new();

    // when set, both sides run back to back with no idle cycles
    bit no_idle = 0;
    int pixels_sent = 0;
    int frames_started = 0;
    int idle_cycles = 0;

    lsb_payload_extractor DUT (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_first_pixel  (s_first_pixel),
        .s_red          (s_red),
        .s_green        (s_green),
        .s_blue         (s_blue),
        .s_alpha        (s_alpha),
        .s_red_count    (s_red_count),
        .s_green_count  (s_green_count),
        .s_blue_count   (s_blue_count),
        .s_alpha_count  (s_alpha_count),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_kind         (m_kind),
        .m_payload_byte (m_payload_byte),
        .m_last         (m_last)
    );

    // 8 ns clock
    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    function automatic int draw_gap();
        return no_idle ? 0 : $urandom_range(0, GAP_MAX);
    endfunction

    // counts mostly in range, some at the top, some above range (clamped to 8)
    function automatic logic [COUNT_W-1:0] draw_count();
        int r;
        r = $urandom_range(0, 19);
        if (r < 14)
            return COUNT_W'($urandom_range(0, CHAN_BITS_MAX));
        else if (r < 17)
            return COUNT_W'(CHAN_BITS_MAX);
        else
            return COUNT_W'($urandom_range(CHAN_BITS_MAX + 1, 15));
    endfunction

    // present one pixel after a random gap and hold it until the transfer
    task automatic send_pixel(input pixel_t px);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_first_pixel <= px.first;
        s_red         <= px.chan[0];
        s_green       <= px.chan[1];
        s_blue        <= px.chan[2];
        s_alpha       <= px.chan[3];
        s_red_count   <= px.cnt[0];
        s_green_count <= px.cnt[1];
        s_blue_count  <= px.cnt[2];
        s_alpha_count <= px.cnt[3];
        do
            @(posedge aclk);
        while (!s_ready);
        board.note_pixel(px);
        pixels_sent++;
    endtask

    // sender holds off until every outstanding result has been checked
    task automatic wait_drained();
        s_valid <= 1'b0;
        do
            @(posedge aclk);
        while (board.pending() != 0);
    endtask

    // build the pixels of one frame: the header bits encode frame_len, the rest is random
    task automatic play_frame(input logic [63:0] frame_len, input bit restart,
                              input count_mode_t mode, input int extra_bits,
                              input int max_pixels);
        logic [64:0] stop_bit;
        logic [64:0] bit_idx;
        int          npix;
        int          c;
        pixel_t      px;
        stop_bit = ((frame_len < 72) ? 65'd64 : {1'b0, frame_len}) + extra_bits;
        bit_idx  = '0;
        npix     = 0;
        frames_started++;
        while (bit_idx < stop_bit && npix < max_pixels) begin
            px.first = (npix == 0) && restart;
            for (int ch = 0; ch < LANES; ch++) begin
                case (mode)
                    COUNTS_FULL: px.cnt[ch] = COUNT_W'(CHAN_BITS_MAX);
                    COUNTS_OVER: px.cnt[ch] = 4'd15;
                    default:     px.cnt[ch] = draw_count();
                endcase
                px.chan[ch] = CHAN_W'($urandom);
                c = (px.cnt[ch] > CHAN_BITS_MAX) ? CHAN_BITS_MAX : int'(px.cnt[ch]);
                for (int j = c - 1; j >= 0; j--) begin
                    // header bits go out big-endian, payload bits stay random
                    if (bit_idx < HDR_BITS)
                        px.chan[ch][j] = frame_len[63 - int'(bit_idx[6:0])];
                    bit_idx++;
                end
            end
            send_pixel(px);
            npix++;
        end
    endtask

    // pixels with every field random, restart now and then
    task automatic play_noise(input int n);
        pixel_t px;
        repeat (n) begin
            px.first = ($urandom_range(0, 3) == 0);
            for (int ch = 0; ch < LANES; ch++) begin
                px.chan[ch] = CHAN_W'($urandom);
                px.cnt[ch]  = COUNT_W'($urandom_range(0, 15));
            end
            send_pixel(px);
        end
    endtask

    // result side: random stalls before each transfer
    initial begin
        int stall;
        m_ready <= 1'b0;
        do
            @(posedge aclk);
        while (!aresetn);
        forever begin
            stall = draw_gap();
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do
                @(posedge aclk);
            while (!m_valid);
        end
    end

    // result monitor, sampled at the edge where the transfer happens
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            board.check_result(m_kind, m_payload_byte, m_last);
    end

    // watchdog on cycles with no transfer on either channel
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_CYCLES) begin
                $display("timeout: no transfer for %0d cycles at %0t", idle_cycles, $realtime);
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    initial begin
        pixel_t      px;
        int          r;
        int          random_start;
        int          frame_no;
        logic [63:0] frame_len;

        // every input known from time zero
        aresetn       <= 1'b0;
        s_valid       <= 1'b0;
        s_first_pixel <= 1'b0;
        s_red         <= '0;
        s_green       <= '0;
        s_blue        <= '0;
        s_alpha       <= '0;
        s_red_count   <= '0;
        s_green_count <= '0;
        s_blue_count  <= '0;
        s_alpha_count <= '0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // ---- directed part ----
        // first frame after reset without a restart flag, two payload bytes
        play_frame(64'd80, 1'b0, COUNTS_FULL, 0, 20);
        // header length zero and just below the header size: bad header
        play_frame(64'd0, 1'b1, COUNTS_FULL, 0, 20);
        play_frame(64'd63, 1'b1, COUNTS_OVER, 0, 20);
        // exactly a header, and a header plus seven stray bits: empty payload
        play_frame(64'd64, 1'b1, COUNTS_FULL, 0, 20);
        play_frame(64'd71, 1'b1, COUNTS_FULL, 0, 20);
        // four bytes out of one pixel, then a partial byte that is dropped
        play_frame(64'd101, 1'b1, COUNTS_FULL, 0, 20);
        // frame finished: extreme pixels without restart are ignored
        px.first = 1'b0;
        px.chan  = '0;
        px.cnt   = '0;
        send_pixel(px);
        px.chan  = '1;
        px.cnt   = '1;
        send_pixel(px);
        // restart in the middle of a header
        play_frame(64'd200, 1'b1, COUNTS_RANDOM, 0, 1);
        // largest possible length, broken off after three pixels
        play_frame('1, 1'b1, COUNTS_FULL, 0, 3);

        // ---- random part ----
        random_start = pixels_sent;
        frame_no     = 0;
        while (pixels_sent - random_start < RANDOM_PIXELS) begin
            // bursts with no idling on either side
            no_idle = ($urandom_range(0, 4) == 0);
            // sender holds off until the block has drained
            if (frame_no == 10 || $urandom_range(0, 11) == 0)
                wait_drained();
            r = $urandom_range(0, 99);
            if (r < 8) begin
                frame_len = 64'($urandom_range(0, HDR_BITS - 1));
                play_frame(frame_len, $urandom_range(0, 9) != 0, COUNTS_RANDOM,
                           $urandom_range(0, 40), 100);
            end else if (r < 16) begin
                frame_len = 64'($urandom_range(HDR_BITS, HDR_BITS + 7));
                play_frame(frame_len, $urandom_range(0, 9) != 0, COUNTS_RANDOM,
                           $urandom_range(0, 40), 100);
            end else if (r < 20) begin
                // huge length, never completes before the next frame
                frame_len = {1'b1, 31'($urandom), 32'($urandom)};
                if ($urandom_range(0, 3) == 0)
                    frame_len = '1;
                play_frame(frame_len, 1'b1, COUNTS_RANDOM, 0, $urandom_range(4, 8));
            end else if (r < 28) begin
                // frame broken off after a few pixels
                frame_len = 64'(72 + 8 * $urandom_range(0, 24) + $urandom_range(0, 7));
                play_frame(frame_len, 1'b1, COUNTS_RANDOM, 0, $urandom_range(1, 3));
            end else if (r < 36) begin
                play_noise($urandom_range(1, 6));
            end else begin
                frame_len = 64'(72 + 8 * $urandom_range(0, 24) + $urandom_range(0, 7));
                play_frame(frame_len, $urandom_range(0, 9) != 0, COUNTS_RANDOM,
                           $urandom_range(0, 40), 100);
            end
            frame_no++;
        end
        no_idle = 0;

        // ---- drain ----
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("covered %0d pixels in %0d frames; checked %0d bytes, %0d empty, %0d bad",
                 pixels_sent, frames_started, board.bytes_seen, board.empty_seen,
                 board.bad_seen);
        $display("%0d mismatches, %0d results still outstanding",
                 board.mismatches, board.pending());
        if (board.mismatches == 0 && board.pending() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

[lsb_payload_extractor.f]
rtl/lpe_pkg.sv
rtl/lpe_lane.sv
rtl/lpe_merge.sv
rtl/lpe_header.sv
rtl/lpe_payload.sv
rtl/lsb_payload_extractor.sv
tb/tb_lsb_payload_extractor.sv
